/* hw/rtl/dss_pkg.sv */
// Shared widths and codes for the deadline slot scheduler.
package dss_pkg;

  localparam int JOB_ID_W   = 16;
  localparam int DEADLINE_W = 16;
  localparam int SLOT_W     = 8;
  localparam int RANK_W     = 4;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_SCHED = 1'b1
  } action_t;

endpackage

/* hw/rtl/dss_if.sv */
// Job and result channel interfaces for the deadline slot scheduler.
interface dss_job_if;
  import dss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [JOB_ID_W-1:0]   job_id;
  logic [DEADLINE_W-1:0] deadline;

  modport source (output valid, action, job_id, deadline, input ready);
  modport sink   (input valid, action, job_id, deadline, output ready);
endinterface

interface dss_result_if;
  import dss_pkg::*;

  logic                valid;
  logic                ready;
  logic                accepted;
  logic [SLOT_W-1:0]   slot;
  logic [JOB_ID_W-1:0] job_echo;
  logic                deadline_clamped;

  modport source (output valid, accepted, slot, job_echo, deadline_clamped, input ready);
  modport sink   (input valid, accepted, slot, job_echo, deadline_clamped, output ready);
endinterface

/* hw/rtl/deadline_slot_scheduler.sv */
// Deadline slot scheduler: greedy slot assignment over a disjoint-set forest in one memory.
//
// Each job transaction finds the latest free slot at or before its deadline and
// returns one result transaction. All set state (parent, depth rank, smallest
// member) lives in one synchronous memory of MAX_DEADLINE+1 words, with one read
// port and one write port. A job makes three root searches, each walking a tree
// at most log2(MAX_DEADLINE+1) levels deep, then merges the two sets found (unless
// they are one set) by writing the subordinate root and then the top root, emits
// its result and returns to idle before the next job is taken; a job that finds no
// free slot stops after the first search. The next job is taken while a finished
// result still waits at the output. After reset, and after every start transaction,
// a clearing pass rewrites every slot as a singleton; no job is taken during that
// pass.
module deadline_slot_scheduler #(
  parameter int MAX_DEADLINE = 255
) (
  input  logic          clk,
  input  logic          rst_n,
  dss_job_if.sink       in_ch,
  dss_result_if.source  out_ch
);
  import dss_pkg::*;

  localparam int NSLOTS = MAX_DEADLINE + 1;
  localparam int IW     = (NSLOTS > 2) ? $clog2(NSLOTS) : 1;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [IW-1:0]     smallest;
    logic [IW-1:0]     parent;
  } slot_word_t;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_FINDD = 8'b0000_0100,
    ST_FINDS = 8'b0000_1000,
    ST_FINDQ = 8'b0001_0000,
    ST_WRSUB = 8'b0010_0000,
    ST_WRTOP = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  slot_word_t slot_mem [NSLOTS];

  state_t              state_r, state_nxt;
  slot_word_t          rd_word_r;
  logic [IW-1:0]       node_r;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  slot_word_t          wr_data;
  logic [IW-1:0]       clr_r;
  logic                start_r;
  logic                acc_r;
  logic                clamp_r;
  logic [IW-1:0]       dl_r;
  logic [IW-1:0]       slot_r;
  logic [JOB_ID_W-1:0] id_r;
  logic [IW-1:0]       p_r, q_r;
  slot_word_t          pw_r, qw_r;

  logic                out_valid_r;
  logic                o_acc_r;
  logic [SLOT_W-1:0]   o_slot_r;
  logic [JOB_ID_W-1:0] o_id_r;
  logic                o_clamp_r;

  logic                in_fire;
  logic                out_free;
  logic                is_root;
  logic                dl_over;
  logic [IW-1:0]       dl_sat;
  logic                top_is_p;
  logic                rank_eq;
  logic [IW-1:0]       top_idx, sub_idx;
  slot_word_t          top_w, sub_w;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_root     = (rd_word_r.parent == node_r);
  assign dl_over     = in_ch.deadline > DEADLINE_W'(MAX_DEADLINE);
  assign dl_sat      = dl_over ? IW'(MAX_DEADLINE) : IW'(in_ch.deadline);

  assign rank_eq  = (pw_r.rank == qw_r.rank);
  assign top_is_p = (pw_r.rank >= qw_r.rank);
  assign top_idx  = top_is_p ? p_r : q_r;
  assign sub_idx  = top_is_p ? q_r : p_r;
  assign top_w    = top_is_p ? pw_r : qw_r;
  assign sub_w    = top_is_p ? qw_r : pw_r;

  always_comb begin
    state_nxt = state_r;
    rd_addr   = rd_word_r.parent;
    wr_en     = 1'b0;
    wr_addr   = clr_r;
    wr_data   = '{rank: '0, smallest: clr_r, parent: clr_r};
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_r == IW'(MAX_DEADLINE)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = dl_sat;
        if (in_fire) begin
          state_nxt = (in_ch.action == ACT_SCHED) ? ST_FINDD : ST_EMIT;
        end
      end
      ST_FINDD: begin
        if (is_root) begin
          rd_addr   = rd_word_r.smallest;
          state_nxt = (rd_word_r.smallest == '0) ? ST_EMIT : ST_FINDS;
        end
      end
      ST_FINDS: begin
        if (is_root) begin
          rd_addr   = slot_r - IW'(1);
          state_nxt = ST_FINDQ;
        end
      end
      ST_FINDQ: begin
        if (is_root) begin
          state_nxt = ST_WRSUB;
        end
      end
      ST_WRSUB: begin
        if (p_r == q_r) begin
          state_nxt = ST_EMIT;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = sub_idx;
          wr_data   = '{rank: sub_w.rank, smallest: sub_w.smallest, parent: top_idx};
          state_nxt = ST_WRTOP;
        end
      end
      ST_WRTOP: begin
        wr_en        = 1'b1;
        wr_addr      = top_idx;
        wr_data.rank = rank_eq ? top_w.rank + RANK_W'(1) : top_w.rank;
        wr_data.smallest = (sub_w.smallest < top_w.smallest) ? sub_w.smallest
                                                             : top_w.smallest;
        wr_data.parent   = top_w.parent;
        state_nxt        = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = start_r ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_word_r <= slot_mem[rd_addr];
    node_r    <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + IW'(1);
      end else begin
        clr_r <= '0;
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      start_r <= (in_ch.action == ACT_START);
      clamp_r <= (in_ch.action == ACT_SCHED) && dl_over;
      dl_r    <= dl_sat;
      id_r    <= in_ch.job_id;
      acc_r   <= 1'b0;
    end
    if (state_r == ST_FINDD && is_root) begin
      slot_r <= rd_word_r.smallest;
      acc_r  <= (rd_word_r.smallest != '0);
    end
    if (state_r == ST_FINDS && is_root) begin
      p_r  <= node_r;
      pw_r <= rd_word_r;
    end
    if (state_r == ST_FINDQ && is_root) begin
      q_r  <= node_r;
      qw_r <= rd_word_r;
    end
    if (state_r == ST_EMIT && out_free) begin
      o_acc_r   <= acc_r;
      o_slot_r  <= acc_r ? SLOT_W'(slot_r) : '0;
      o_id_r    <= id_r;
      o_clamp_r <= clamp_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.accepted         = o_acc_r;
  assign out_ch.slot             = o_slot_r;
  assign out_ch.job_echo         = o_id_r;
  assign out_ch.deadline_clamped = o_clamp_r;

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && acc_r) |-> (slot_r != '0 && slot_r <= dl_r))
    else $error("assigned slot outside 1..deadline");

  a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRTOP) |-> (p_r != q_r))
    else $error("merge of a set with itself");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINDD || state_r == ST_FINDS || state_r == ST_FINDQ)
      |-> (node_r <= IW'(MAX_DEADLINE)))
    else $error("set walk left the slot range");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && start_r) |=> (state_r == ST_CLEAR && !o_acc_r))
    else $error("start transaction not followed by clearing pass");

endmodule
